// ----- rtl/ccc_pkg.sv -----
package ccc_pkg;

	localparam int unsigned CountW     = 16;
	localparam int unsigned RsW        = 20;
	localparam int unsigned PsW        = 3;
	localparam int unsigned DcW        = 32;
	localparam int unsigned ResW       = 32;
	localparam int unsigned CfgDataW   = 32;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned PrescRefW  = 7;
	localparam int unsigned LsbW       = 13;
	localparam int unsigned CntProdW   = CountW + LsbW;
	localparam int unsigned UahProdW   = ResW + RsW;
	localparam int unsigned XNumW      = UahProdW + PrescRefW;
	localparam int unsigned DenW       = RsW + PrescRefW;
	localparam int unsigned YNumW      = CntProdW + PrescRefW;
	localparam int unsigned ZNumW      = ResW + 7;
	localparam int unsigned ZDenW      = ResW;
	localparam int unsigned QueueDepth = 4;

	localparam logic [CountW-1:0] FullCount = '1;
	localparam logic [LsbW-1:0] LsbProd = LsbW'(85 * 50);
	localparam logic [CntProdW-1:0] FullProd = CntProdW'((2 ** CountW - 1) * (85 * 50));
	localparam logic [6:0] PctScale = 7'd100;
	localparam logic [ZDenW-1:0] MahDiv = ZDenW'(1000);

	localparam logic [RsW-1:0] RsenseRst = RsW'(50);
	localparam logic [PsW-1:0] PrescRst  = PsW'(7);
	localparam logic [DcW-1:0] DcapRst   = '0;

	typedef enum logic [2:0] {
		OP_CNT2UAH   = 3'd0,
		OP_UAH2CNT   = 3'd1,
		OP_FULLCAP   = 3'd2,
		OP_SOC       = 3'd3,
		OP_DESIGN_MAH = 3'd4
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RSENSE = 2'd0,
		REG_PRESC  = 2'd1,
		REG_DCAP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [XNumW-1:0] x_num;
		logic [DenW-1:0]  x_den;
		logic [YNumW-1:0] y_num;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/ccc_front.sv -----
module ccc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     opcode,
	input  logic [ccc_pkg::CountW-1:0]     charge_count,
	input  logic [ccc_pkg::ResW-1:0]       charge_uah,
	input  logic [ccc_pkg::RsW-1:0]        rsense,
	input  logic [ccc_pkg::PsW-1:0]        presc,
	input  ccc_pkg::q_stat_t               q_stat,
	output logic                           push,
	output ccc_pkg::job_t                  job
);

	logic [ccc_pkg::CntProdW-1:0] cnt_prod;
	logic [ccc_pkg::UahProdW-1:0] uah_prod;
	ccc_pkg::job_t                job_d;
	ccc_pkg::job_t                job_s1;
	logic                         vld_s1;
	logic                         load;

	assign cnt_prod = ccc_pkg::CntProdW'(charge_count) * ccc_pkg::CntProdW'(ccc_pkg::LsbProd);
	assign uah_prod = ccc_pkg::UahProdW'(charge_uah) * ccc_pkg::UahProdW'(rsense);

	always_comb begin
		job_d.op    = ccc_pkg::op_t'(opcode);
		job_d.y_num = ccc_pkg::YNumW'(ccc_pkg::FullProd) << presc;
		case (ccc_pkg::op_t'(opcode))
			ccc_pkg::OP_UAH2CNT: begin
				job_d.x_num = {uah_prod, ccc_pkg::PrescRefW'(0)};
				job_d.x_den = ccc_pkg::DenW'(ccc_pkg::LsbProd) << presc;
			end
			default: begin
				job_d.x_num = ccc_pkg::XNumW'(cnt_prod) << presc;
				job_d.x_den = {rsense, ccc_pkg::PrescRefW'(0)};
			end
		endcase
	end

	assign in_stall = vld_s1 && q_stat.full;
	assign load     = in_valid && !in_stall;
	assign push     = vld_s1 && !q_stat.full;
	assign job      = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job_d;
		end
	end

endmodule

// ----- rtl/ccc_queue.sv -----
module ccc_queue #(
	parameter int unsigned DEPTH = ccc_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ccc_pkg::job_t    push_job,
	input  logic             pop,
	output ccc_pkg::job_t    head,
	output ccc_pkg::q_stat_t q_stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	ccc_pkg::job_t   mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		if (p == PtrW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PtrW'(1);
	endfunction

	assign q_stat.full  = (count_q == CntW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- rtl/ccc_div.sv -----
module ccc_div #(
	parameter int unsigned NW = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [DW-1:0] den_o,
	output logic [TW-1:0] tag_o
);

	logic          vld_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] r_in;
		logic [NW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [TW-1:0] t_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign q_in = num;
			assign d_in = den;
			assign t_in = tag;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
			assign t_in = tag_s[k-1];
		end

		assign trial = {r_in, q_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				if (NW > 1) begin
					quo_s[k] <= {q_in[NW-2:0], ge};
				end else begin
					quo_s[k] <= NW'(ge);
				end
				den_s[k] <= d_in;
				tag_s[k] <= t_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign rem       = rem_s[NW-1];
	assign den_o     = den_s[NW-1];
	assign tag_o     = tag_s[NW-1];

endmodule

// ----- rtl/ccc_back.sv -----
module ccc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccc_pkg::q_stat_t           q_stat,
	input  ccc_pkg::job_t              head,
	output logic                       pop,
	input  logic [ccc_pkg::RsW-1:0]    rsense,
	input  logic [ccc_pkg::DcW-1:0]    dcap,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ccc_pkg::ResW-1:0]   result_value,
	output logic                       unsupported
);

	localparam int unsigned QW = ccc_pkg::XNumW + 1;

	typedef struct packed {
		ccc_pkg::op_t               op;
		logic [ccc_pkg::ResW-1:0]   res;
		logic                       unsup;
		logic                       full0;
		logic                       sat100;
	} ztag_t;

	localparam int unsigned ZTW = $bits(ztag_t);

	logic                         adv;
	logic                         x_vld;
	logic [ccc_pkg::XNumW-1:0]    x_quo;
	logic [ccc_pkg::DenW-1:0]     x_rem;
	logic [ccc_pkg::DenW-1:0]     x_den;
	logic [2:0]                   x_op;
	logic [ccc_pkg::XNumW-1:0]    y_quo;
	logic [ccc_pkg::DenW-1:0]     y_rem;
	logic [ccc_pkg::DenW-1:0]     y_den;
	logic [QW-1:0]                x_q;
	logic [QW-1:0]                y_q;
	logic [ccc_pkg::ResW-1:0]     x_uah;
	logic [ccc_pkg::ResW-1:0]     y_uah;
	logic [ccc_pkg::ResW-1:0]     x_cnt;
	logic [ccc_pkg::ResW-1:0]     full_cap;
	logic [ccc_pkg::ResW-1:0]     val_d;

	logic                         vld_s1;
	ccc_pkg::op_t                 op_s1;
	logic [ccc_pkg::ResW-1:0]     val_s1;
	logic [ccc_pkg::ResW-1:0]     full_s1;

	logic [ccc_pkg::ZNumW-1:0]    pct_num;
	logic [ccc_pkg::ZNumW-1:0]    z_num_d;
	logic [ccc_pkg::ZDenW-1:0]    z_den_d;
	ztag_t                        ztag_d;

	logic                         vld_s2;
	logic [ccc_pkg::ZNumW-1:0]    z_num_s2;
	logic [ccc_pkg::ZDenW-1:0]    z_den_s2;
	ztag_t                        ztag_s2;

	logic                         z_vld;
	logic [ccc_pkg::ZNumW-1:0]    z_quo;
	logic [ZTW-1:0]               z_tag_raw;
	ztag_t                        z_tag;
	logic [ccc_pkg::ResW-1:0]     fin_res;
	logic                         fin_unsup;

	logic                         out_valid_q;
	logic [ccc_pkg::ResW-1:0]     result_q;
	logic                         unsup_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_stat.empty;

	ccc_div #(
		.NW(ccc_pkg::XNumW),
		.DW(ccc_pkg::DenW),
		.TW(3)
	) u_xdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (!q_stat.empty),
		.num      (head.x_num),
		.den      (head.x_den),
		.tag      (head.op),
		.out_valid(x_vld),
		.quo      (x_quo),
		.rem      (x_rem),
		.den_o    (x_den),
		.tag_o    (x_op)
	);

	ccc_div #(
		.NW(ccc_pkg::XNumW),
		.DW(ccc_pkg::DenW),
		.TW(1)
	) u_ydiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (!q_stat.empty),
		.num      (ccc_pkg::XNumW'(head.y_num)),
		.den      ({rsense, ccc_pkg::PrescRefW'(0)}),
		.tag      (1'b0),
		.out_valid(),
		.quo      (y_quo),
		.rem      (y_rem),
		.den_o    (y_den),
		.tag_o    ()
	);

	// round half up, then saturate
	always_comb begin
		x_q = {1'b0, x_quo} + QW'({x_rem, 1'b0} >= {1'b0, x_den});
		y_q = {1'b0, y_quo} + QW'({y_rem, 1'b0} >= {1'b0, y_den});

		if (x_den == '0) begin
			x_uah = '1;
		end else if (|x_q[QW-1:ccc_pkg::ResW]) begin
			x_uah = '1;
		end else begin
			x_uah = x_q[ccc_pkg::ResW-1:0];
		end

		if (y_den == '0) begin
			y_uah = '1;
		end else if (|y_q[QW-1:ccc_pkg::ResW]) begin
			y_uah = '1;
		end else begin
			y_uah = y_q[ccc_pkg::ResW-1:0];
		end

		if (x_q > QW'(ccc_pkg::FullCount)) begin
			x_cnt = ccc_pkg::ResW'(ccc_pkg::FullCount);
		end else begin
			x_cnt = x_q[ccc_pkg::ResW-1:0];
		end

		full_cap = (dcap != '0) ? dcap : y_uah;

		case (ccc_pkg::op_t'(x_op))
			ccc_pkg::OP_UAH2CNT: val_d = x_cnt;
			ccc_pkg::OP_FULLCAP: val_d = full_cap;
			default:             val_d = x_uah;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= x_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= ccc_pkg::op_t'(x_op);
			val_s1   <= val_d;
			full_s1  <= full_cap;
			z_num_s2 <= z_num_d;
			z_den_s2 <= z_den_d;
			ztag_s2  <= ztag_d;
		end
	end

	always_comb begin
		pct_num = ccc_pkg::ZNumW'(val_s1) * ccc_pkg::ZNumW'(ccc_pkg::PctScale)
			+ ccc_pkg::ZNumW'(full_s1 >> 1);
		ztag_d.op     = op_s1;
		ztag_d.full0  = (full_s1 == '0);
		ztag_d.sat100 = (val_s1 >= full_s1);
		case (op_s1)
			ccc_pkg::OP_CNT2UAH,
			ccc_pkg::OP_UAH2CNT,
			ccc_pkg::OP_FULLCAP: begin
				z_num_d      = ccc_pkg::ZNumW'(dcap);
				z_den_d      = ccc_pkg::MahDiv;
				ztag_d.res   = val_s1;
				ztag_d.unsup = 1'b0;
			end
			ccc_pkg::OP_SOC: begin
				z_num_d      = pct_num;
				z_den_d      = full_s1;
				ztag_d.res   = '0;
				ztag_d.unsup = 1'b0;
			end
			ccc_pkg::OP_DESIGN_MAH: begin
				z_num_d      = ccc_pkg::ZNumW'(dcap);
				z_den_d      = ccc_pkg::MahDiv;
				ztag_d.res   = '0;
				ztag_d.unsup = (dcap == '0);
			end
			default: begin
				z_num_d      = ccc_pkg::ZNumW'(dcap);
				z_den_d      = ccc_pkg::MahDiv;
				ztag_d.res   = '0;
				ztag_d.unsup = 1'b1;
			end
		endcase
	end

	ccc_div #(
		.NW(ccc_pkg::ZNumW),
		.DW(ccc_pkg::ZDenW),
		.TW(ZTW)
	) u_zdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s2),
		.num      (z_num_s2),
		.den      (z_den_s2),
		.tag      (ztag_s2),
		.out_valid(z_vld),
		.quo      (z_quo),
		.rem      (),
		.den_o    (),
		.tag_o    (z_tag_raw)
	);

	assign z_tag = ztag_t'(z_tag_raw);

	always_comb begin
		fin_unsup = z_tag.unsup;
		case (z_tag.op)
			ccc_pkg::OP_SOC: begin
				if (z_tag.full0) begin
					fin_res = '0;
				end else if (z_tag.sat100) begin
					fin_res = ccc_pkg::ResW'(ccc_pkg::PctScale);
				end else begin
					fin_res = z_quo[ccc_pkg::ResW-1:0];
				end
			end
			ccc_pkg::OP_DESIGN_MAH: begin
				fin_res = z_tag.unsup ? '0 : z_quo[ccc_pkg::ResW-1:0];
			end
			default: begin
				fin_res = z_tag.res;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= z_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= fin_res;
			unsup_q  <= fin_unsup;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign unsupported  = unsup_q;

endmodule

// ----- rtl/coulomb_count_charge_converter.sv -----
// Throughput: one transaction per cycle while out_stall is low;
// the 59-stage and 39-stage pipelined dividers set latency.
// A four-entry queue between the input stage and the divider pipeline absorbs output stalls.
// Reset (arst_n low, asynchronous) empties all stages and loads the register defaults.
module coulomb_count_charge_converter #(
	parameter int unsigned QUEUE_DEPTH = ccc_pkg::QueueDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ccc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [ccc_pkg::CfgDataW-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      opcode,
	input  logic [ccc_pkg::CountW-1:0]      charge_count,
	input  logic [ccc_pkg::ResW-1:0]        charge_uah,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ccc_pkg::ResW-1:0]        result_value,
	output logic                            unsupported
);

	logic [ccc_pkg::RsW-1:0] rsense_q;
	logic [ccc_pkg::PsW-1:0] presc_q;
	logic [ccc_pkg::DcW-1:0] dcap_q;
	ccc_pkg::q_stat_t        q_stat;
	ccc_pkg::job_t           push_job;
	ccc_pkg::job_t           head;
	logic                    push;
	logic                    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsense_q <= ccc_pkg::RsenseRst;
			presc_q  <= ccc_pkg::PrescRst;
			dcap_q   <= ccc_pkg::DcapRst;
		end else if (cfg_we) begin
			case (cfg_index)
				ccc_pkg::REG_RSENSE: rsense_q <= cfg_wdata[ccc_pkg::RsW-1:0];
				ccc_pkg::REG_PRESC:  presc_q  <= cfg_wdata[ccc_pkg::PsW-1:0];
				ccc_pkg::REG_DCAP:   dcap_q   <= cfg_wdata[ccc_pkg::DcW-1:0];
				default: ;
			endcase
		end
	end

	ccc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.charge_count(charge_count),
		.charge_uah  (charge_uah),
		.rsense      (rsense_q),
		.presc       (presc_q),
		.q_stat      (q_stat),
		.push        (push),
		.job         (push_job)
	);

	ccc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	ccc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.rsense      (rsense_q),
		.dcap        (dcap_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.unsupported (unsupported)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled while queue has room");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> result_value == '0)
		else $error("unsupported result carries a nonzero value");
`endif

endmodule

// ----- bench/tb_coulomb_count_charge_converter.sv -----
`timescale 1ns / 1ps

module tb_coulomb_count_charge_converter;
	import ccc_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic        unsup;
	} conv_result_t;

	class conversion_scoreboard;
		logic [19:0] rsense;
		logic [2:0]  presc;
		logic [31:0] dcap;
		conv_result_t pending[$];
		int mismatches;

		function new();
			rsense = RsenseRst;
			presc = PrescRst;
			dcap = DcapRst;
			mismatches = 0;
		endfunction

		function logic [31:0] round_div_sat(logic [127:0] n, logic [127:0] d);
			logic [127:0] q;
			if (d == 0) return 32'hFFFF_FFFF;
			q = n / d;
			if ((n % d) >= d - d / 2) q++;
			return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		function logic [31:0] counts_to_uah(logic [15:0] c);
			logic [127:0] m;
			m = 128'd1 << presc;
			return round_div_sat(128'(c) * 85 * 50 * m, 128'(rsense) * 128);
		endfunction

		function logic [31:0] full_cap();
			return (dcap != 0) ? dcap : counts_to_uah(FullCount);
		endfunction

		function void note_input(logic [2:0] op, logic [15:0] cnt, logic [31:0] uah);
			conv_result_t r;
			logic [31:0] c, rem, full;
			logic [127:0] p;
			r.value = 0;
			r.unsup = 0;
			case (op)
				OP_CNT2UAH: r.value = counts_to_uah(cnt);
				OP_UAH2CNT: begin
					c = round_div_sat(128'(uah) * rsense * 128, 128'd4250 * (128'd1 << presc));
					r.value = (c > 32'hFFFF) ? 32'hFFFF : c;
				end
				OP_FULLCAP: r.value = full_cap();
				OP_SOC: begin
					rem = counts_to_uah(cnt);
					full = full_cap();
					if (full == 0) r.value = 0;
					else if (rem >= full) r.value = 100;
					else begin
						p = (128'(rem) * 100 + full / 2) / full;
						r.value = (p > 100) ? 100 : p[31:0];
					end
				end
				OP_DESIGN_MAH: begin
					if (dcap == 0) r.unsup = 1;
					else r.value = dcap / 1000;
				end
				default: r.unsup = 1;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] v, logic u);
			conv_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %b", v, u);
				return;
			end
			e = pending.pop_front();
			if (e.value !== v || e.unsup !== u) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h/%b actual %h/%b", e.value, e.unsup, v, u);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxW-1:0] cfg_index = REG_RSENSE;
	logic [CfgDataW-1:0] cfg_wdata = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0, unsupported;
	logic [2:0] opcode = OP_CNT2UAH;
	logic [15:0] charge_count = 0;
	logic [31:0] charge_uah = 0, result_value;
	int burst_left = 0;

	conversion_scoreboard sb = new();

	coulomb_count_charge_converter DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(result_value, unsupported);
		case (($time / 2000) % 3)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_RSENSE: sb.rsense = val[19:0];
			REG_PRESC:  sb.presc = val[2:0];
			default:    sb.dcap = val;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	task automatic send(logic [2:0] op, logic [15:0] cnt, logic [31:0] uah);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1;
		opcode <= op;
		charge_count <= cnt;
		charge_uah <= uah;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, cnt, uah);
	endtask

	function automatic logic [31:0] rand_uah();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1000);
			1: return $urandom_range(0, 2000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int n);
		repeat (n) send(3'($urandom_range(0, 7)), 16'($urandom), rand_uah());
		in_valid <= 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(OP_CNT2UAH, 0, 0);
		send(OP_CNT2UAH, 16'hFFFF, 0);
		send(OP_CNT2UAH, 1, 0);
		send(OP_UAH2CNT, 0, 0);
		send(OP_UAH2CNT, 0, 32'hFFFF_FFFF);
		send(OP_UAH2CNT, 0, 85);
		send(OP_FULLCAP, 0, 0);
		send(OP_SOC, 16'hFFFF, 0);
		send(OP_SOC, 16'h7FFF, 0);
		send(OP_SOC, 0, 0);
		send(OP_DESIGN_MAH, 0, 0);
		send(5, 16'hFFFF, 32'hFFFF_FFFF);
		send(6, 0, 0);
		send(7, 0, 0);
		in_valid <= 0;
		drain();
		write_reg(REG_RSENSE, 0);
		write_reg(REG_PRESC, 0);
		write_reg(REG_DCAP, 32'hFFFF_FFFF);
		send(OP_CNT2UAH, 5, 0);
		send(OP_FULLCAP, 0, 0);
		send(OP_SOC, 16'hFFFF, 0);
		send(OP_DESIGN_MAH, 0, 0);
		send(OP_UAH2CNT, 0, 32'hFFFF_FFFF);
		in_valid <= 0;
		drain();
		random_items(150);
		drain();
		write_reg(REG_RSENSE, 1000000);
		write_reg(REG_PRESC, 7);
		write_reg(REG_DCAP, 0);
		random_items(150);
		drain();
		write_reg(REG_RSENSE, 1);
		write_reg(REG_PRESC, 3);
		write_reg(REG_DCAP, 999);
		random_items(150);
		drain();
		repeat (4) begin
			write_reg(REG_RSENSE, $urandom_range(0, 1000000));
			write_reg(REG_PRESC, $urandom_range(0, 7));
			write_reg(REG_DCAP, ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5000));
			random_items(150);
			drain();
		end
		write_reg(REG_RSENSE, $urandom_range(0, 1000000));
		write_reg(REG_PRESC, 5);
		write_reg(REG_DCAP, 32'hFFFF_FFFF);
		random_items(1);
		drain();
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end
endmodule
